/* sv/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle rotation matrix
// Word formats that travel between the cell chains, Q30 angle constants and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ENTRY_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;

    localparam int AXIS_W     = 16;
    localparam int ANGLE_W    = 16;
    localparam int ENTRY_W    = ENTRY_FRAC_BITS + 2;
    localparam int N_ENTRIES  = 9;
    localparam int IN_DATA_W  = 3 * AXIS_W + ANGLE_W;
    localparam int OUT_DATA_W = ((N_ENTRIES * ENTRY_W + 7) / 8) * 8;

    localparam int N2_W       = 2 * AXIS_W;
    localparam int RAD_W      = 60;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 2;

    localparam int UNIT_SHIFT = 44;
    localparam int DIVD_W     = AXIS_W + UNIT_SHIFT;
    localparam int DIV_STEPS  = 31;

    localparam int UNIT_W     = 32;
    localparam int XY_W       = 33;
    localparam int Z_W        = 34;
    localparam int ANG_W      = 36;
    localparam int ATAN_W     = 30;
    localparam int STEP_IDX_W = 5;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;

    localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic [RAD_W-1:0]           rad;
        logic [SQ_REM_W-1:0]        rem;
        logic [ROOT_W-1:0]          root;
        logic signed [AXIS_W-1:0]   ax;
        logic signed [AXIS_W-1:0]   ay;
        logic signed [AXIS_W-1:0]   az;
        logic signed [ANGLE_W-1:0]  angle;
        logic                       zero;
    } sq_word_t;

    typedef struct packed {
        logic [2:0][DIV_STEPS-1:0]  low;
        logic [2:0][ROOT_W-1:0]     rem;
        logic [2:0][DIV_STEPS-1:0]  quo;
        logic [2:0]                 neg;
        logic [ROOT_W-1:0]          q;
        logic signed [ANGLE_W-1:0]  angle;
        logic                       zero;
    } div_word_t;

    typedef struct packed {
        logic signed [XY_W-1:0]      x;
        logic signed [XY_W-1:0]      y;
        logic signed [Z_W-1:0]       z;
        logic                        flip;
        logic [2:0][UNIT_W-1:0]      u;
        logic                        zero;
    } cd_word_t;

endpackage

/* sv/axis_angle_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: 3x3 rotation matrix from an axis and an angle
// Normalises the axis, takes sine and cosine by CORDIC and forms the nine
// Rodrigues entries in signed Q1.16.
//
// Input word (s_): three signed 16-bit axis components of any scale and a
// signed Q3.12 angle in radians. Output word (m_): the nine entries, row by
// row, and a tuser flag raised for an all-zero axis, which yields identity.
// The pipeline is one register for the squared norm, 30 square-root cells,
// 31 division cells, one angle-reduction stage, 16 CORDIC cells and three
// matrix stages. One word is taken every cycle unless the output stalls; the
// cell chains are fully pipelined and items are independent.
// The whole pipeline advances together: while the output word is held by
// a low m_tready, s_tready drops and every stage holds. Reset empties the
// pipeline; no word is in flight afterwards.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
    input  logic [aarm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (ENTRY_W bits each), zero pad
    output logic [aarm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // zero_axis [0]
    output logic                                m_tuser
);
    import aarm_pkg::*;

    logic en;

    logic signed [AXIS_W-1:0]  in_ax, in_ay, in_az;
    logic signed [ANGLE_W-1:0] in_angle;
    logic signed [N2_W-1:0]    sqx, sqy, sqz;
    logic [N2_W-1:0]           n2;
    sq_word_t                  sq0_next;

    sq_word_t  sq_w [SQRT_STEPS+1];
    logic      sq_v [SQRT_STEPS+1];
    div_word_t dv_w [DIV_STEPS+1];
    logic      dv_v [DIV_STEPS+1];
    cd_word_t  cd_w [CORDIC_STEPS+1];
    logic      cd_v [CORDIC_STEPS+1];

    logic [2:0][AXIS_W-1:0]    mag;
    logic [2:0][DIVD_W-1:0]    divd;
    logic signed [ANG_W-1:0]   r0, r1, r2, r3;
    logic                      flip;
    cd_word_t                  cd0_next;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // squared norm and radicand
    always_comb begin
        in_ax    = $signed(s_tdata[AXIS_W-1:0]);
        in_ay    = $signed(s_tdata[2*AXIS_W-1:AXIS_W]);
        in_az    = $signed(s_tdata[3*AXIS_W-1:2*AXIS_W]);
        in_angle = $signed(s_tdata[IN_DATA_W-1:3*AXIS_W]);
        sqx      = N2_W'(in_ax) * N2_W'(in_ax);
        sqy      = N2_W'(in_ay) * N2_W'(in_ay);
        sqz      = N2_W'(in_az) * N2_W'(in_az);
        n2       = N2_W'(sqx) + N2_W'(sqy) + N2_W'(sqz);
        sq0_next.rad   = {n2, (RAD_W-N2_W)'(0)};
        sq0_next.rem   = '0;
        sq0_next.root  = '0;
        sq0_next.ax    = in_ax;
        sq0_next.ay    = in_ay;
        sq0_next.az    = in_az;
        sq0_next.angle = in_angle;
        sq0_next.zero  = (n2 == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v[0] <= 1'b0;
        end else if (en) begin
            sq_v[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_w[0] <= sq0_next;
        end
    end

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        aarm_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_word   (sq_w[i]),
            .out_valid (sq_v[i+1]),
            .out_word  (sq_w[i+1])
        );
    end

    // dividend set-up: |a| * 2^44 + q/2, high part seeds the remainder
    always_comb begin
        mag[0] = sq_w[SQRT_STEPS].ax[AXIS_W-1] ? AXIS_W'(-sq_w[SQRT_STEPS].ax)
                                               : AXIS_W'(sq_w[SQRT_STEPS].ax);
        mag[1] = sq_w[SQRT_STEPS].ay[AXIS_W-1] ? AXIS_W'(-sq_w[SQRT_STEPS].ay)
                                               : AXIS_W'(sq_w[SQRT_STEPS].ay);
        mag[2] = sq_w[SQRT_STEPS].az[AXIS_W-1] ? AXIS_W'(-sq_w[SQRT_STEPS].az)
                                               : AXIS_W'(sq_w[SQRT_STEPS].az);
        dv_w[0].neg[0] = sq_w[SQRT_STEPS].ax[AXIS_W-1];
        dv_w[0].neg[1] = sq_w[SQRT_STEPS].ay[AXIS_W-1];
        dv_w[0].neg[2] = sq_w[SQRT_STEPS].az[AXIS_W-1];
        for (int k = 0; k < 3; k++) begin
            divd[k] = {mag[k], (UNIT_SHIFT)'(0)}
                    + DIVD_W'(sq_w[SQRT_STEPS].root >> 1);
            dv_w[0].rem[k] = ROOT_W'(divd[k][DIVD_W-1:DIV_STEPS]);
            dv_w[0].low[k] = divd[k][DIV_STEPS-1:0];
            dv_w[0].quo[k] = '0;
        end
        dv_w[0].q     = sq_w[SQRT_STEPS].root;
        dv_w[0].angle = sq_w[SQRT_STEPS].angle;
        dv_w[0].zero  = sq_w[SQRT_STEPS].zero;
        dv_v[0]       = sq_v[SQRT_STEPS];
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        aarm_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_word   (dv_w[i]),
            .out_valid (dv_v[i+1]),
            .out_word  (dv_w[i+1])
        );
    end

    // angle reduction into [-pi/2, pi/2] and CORDIC seed
    always_comb begin
        r0 = {{(ANG_W-ANGLE_W-18){dv_w[DIV_STEPS].angle[ANGLE_W-1]}},
              dv_w[DIV_STEPS].angle, 18'b0};
        r1 = (r0 > PI_Q30) ? r0 - TWO_PI_Q30 : r0;
        r2 = (r1 < -PI_Q30) ? r1 + TWO_PI_Q30 : r1;
        flip = 1'b0;
        r3   = r2;
        if (r2 > HALF_PI_Q30) begin
            r3   = r2 - PI_Q30;
            flip = 1'b1;
        end else if (r2 < -HALF_PI_Q30) begin
            r3   = r2 + PI_Q30;
            flip = 1'b1;
        end
        cd0_next.x    = CORDIC_GAIN;
        cd0_next.y    = '0;
        cd0_next.z    = Z_W'(r3);
        cd0_next.flip = flip;
        for (int k = 0; k < 3; k++) begin
            cd0_next.u[k] = dv_w[DIV_STEPS].neg[k]
                          ? UNIT_W'(-UNIT_W'(dv_w[DIV_STEPS].quo[k]))
                          : UNIT_W'(dv_w[DIV_STEPS].quo[k]);
        end
        cd0_next.zero = dv_w[DIV_STEPS].zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_v[0] <= 1'b0;
        end else if (en) begin
            cd_v[0] <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_w[0] <= cd0_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        aarm_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step_idx  (STEP_IDX_W'(i)),
            .in_valid  (cd_v[i]),
            .in_word   (cd_w[i]),
            .out_valid (cd_v[i+1]),
            .out_word  (cd_w[i+1])
        );
    end

    aarm_matrix u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cd_v[CORDIC_STEPS]),
        .in_word  (cd_w[CORDIC_STEPS]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    localparam logic signed [ENTRY_W-1:0] ENTRY_LIM = ENTRY_W'(64'd1 << ENTRY_FRAC_BITS);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_stall_only_on_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held output word");

    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[ENTRY_W-1:0] == ENTRY_W'(ENTRY_LIM)) &&
            (m_tdata[2*ENTRY_W-1:ENTRY_W] == '0) &&
            (m_tdata[5*ENTRY_W-1:4*ENTRY_W] == ENTRY_W'(ENTRY_LIM)))
        else $error("zero axis did not give identity");

    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[ENTRY_W-1:0]) <= ENTRY_LIM) &&
                     ($signed(m_tdata[ENTRY_W-1:0]) >= -ENTRY_LIM))
        else $error("diagonal entry outside saturation bounds");

    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && cd_v[CORDIC_STEPS]) |=> cd_v[CORDIC_STEPS])
        else $error("stage word lost during stall");

endmodule

/* sv/aarm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// aarm_sqrt_cell: one root bit of the squared-norm square root
// Restoring digit step: takes two radicand bits, sets one root bit, registers.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  aarm_pkg::sq_word_t in_word,
    output logic               out_valid,
    output aarm_pkg::sq_word_t out_word
);
    import aarm_pkg::*;

    logic [SQ_REM_W+1:0] rem_shift;
    logic [SQ_REM_W+1:0] trial;
    sq_word_t            word_next;
    sq_word_t            word_reg;
    logic                valid_reg;

    always_comb begin
        rem_shift      = {in_word.rem, in_word.rad[RAD_W-1 -: 2]};
        trial          = (SQ_REM_W+2)'({in_word.root, 2'b01});
        word_next      = in_word;
        word_next.rad  = {in_word.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            word_next.rem  = SQ_REM_W'(rem_shift - trial);
            word_next.root = {in_word.root[ROOT_W-2:0], 1'b1};
        end else begin
            word_next.rem  = SQ_REM_W'(rem_shift);
            word_next.root = {in_word.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* sv/aarm_div_cell.sv */
// ----------------------------------------------------------------------------
// aarm_div_cell: one quotient bit for the three axis components
// Restoring division step of |a| * 2^44 + q/2 by the norm q, per lane.
// ----------------------------------------------------------------------------
module aarm_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  aarm_pkg::div_word_t in_word,
    output logic                out_valid,
    output aarm_pkg::div_word_t out_word
);
    import aarm_pkg::*;

    logic [2:0][ROOT_W:0] rem_shift;
    div_word_t            word_next;
    div_word_t            word_reg;
    logic                 valid_reg;

    always_comb begin
        word_next = in_word;
        for (int k = 0; k < 3; k++) begin
            rem_shift[k]      = {in_word.rem[k], in_word.low[k][DIV_STEPS-1]};
            word_next.low[k]  = {in_word.low[k][DIV_STEPS-2:0], 1'b0};
            if (rem_shift[k] >= {1'b0, in_word.q}) begin
                word_next.rem[k] = ROOT_W'(rem_shift[k] - {1'b0, in_word.q});
                word_next.quo[k] = {in_word.quo[k][DIV_STEPS-2:0], 1'b1};
            end else begin
                word_next.rem[k] = ROOT_W'(rem_shift[k]);
                word_next.quo[k] = {in_word.quo[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* sv/aarm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// aarm_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates (x, y) by plus or minus atan(2^-i) towards z = 0 and registers.
// ----------------------------------------------------------------------------
module aarm_cordic_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [aarm_pkg::STEP_IDX_W-1:0]     step_idx,
    input  logic                                in_valid,
    input  aarm_pkg::cd_word_t                  in_word,
    output logic                                out_valid,
    output aarm_pkg::cd_word_t                  out_word
);
    import aarm_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  dz;
    cd_word_t               word_next;
    cd_word_t               word_reg;
    logic                   valid_reg;

    always_comb begin
        dx        = in_word.y >>> step_idx;
        dy        = in_word.x >>> step_idx;
        dz        = $signed(Z_W'(ATAN_TAB[step_idx]));
        word_next = in_word;
        if (!in_word.z[Z_W-1]) begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - dz;
        end else begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + dz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* sv/aarm_matrix.sv */
// ----------------------------------------------------------------------------
// aarm_matrix: Rodrigues products, entry sums and output register
// Three stages: axis products and u*s, products with t = 1 - c, then sums,
// rounding, saturation and the zero-axis identity into the output word.
// ----------------------------------------------------------------------------
module aarm_matrix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  aarm_pkg::cd_word_t                  in_word,
    output logic                                m_tvalid,
    output logic [aarm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import aarm_pkg::*;

    localparam int MW        = 34;
    localparam int OUT_SHIFT = 30 - ENTRY_FRAC_BITS;
    localparam logic signed [2*MW-1:0] Q30_HALF = (2*MW)'(64'd1 << 29);
    localparam logic signed [MW-1:0]   Q30_ONE  = MW'(64'd1 << 30);
    localparam logic signed [MW:0]     RND      = (MW+1)'((64'd1 << OUT_SHIFT) >> 1);
    localparam logic signed [MW:0]     LIM      = (MW+1)'(64'd1 << ENTRY_FRAC_BITS);
    localparam logic [ENTRY_W-1:0]     ONE_OUT  = ENTRY_W'(64'd1 << ENTRY_FRAC_BITS);

    function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = (2*MW)'(a) * (2*MW)'(b) + Q30_HALF;
        return MW'(p >>> 30);
    endfunction

    function automatic logic [ENTRY_W-1:0] to_out(input logic signed [MW:0] v);
        logic signed [MW:0] r;
        r = (v + RND) >>> OUT_SHIFT;
        if (r > LIM) begin
            r = LIM;
        end
        if (r < -LIM) begin
            r = -LIM;
        end
        return ENTRY_W'(r);
    endfunction

    logic signed [MW-1:0]         ux, uy, uz, cos1, sin1, t1;
    logic signed [5:0][MW-1:0]    p_reg, p_next;
    logic signed [2:0][MW-1:0]    s_reg, s_next;
    logic signed [MW-1:0]         c_reg, t_reg;
    logic                         zero_reg, valid_reg;

    logic signed [5:0][MW-1:0]    q2_reg, q2_next;
    logic signed [2:0][MW-1:0]    s2_reg;
    logic signed [MW-1:0]         c2_reg;
    logic                         zero2_reg, valid2_reg;

    logic signed [N_ENTRIES-1:0][MW:0] e_next;
    logic [OUT_DATA_W-1:0]             data_next, data_reg;
    logic                              user_reg, out_valid_reg;

    always_comb begin
        ux     = MW'($signed(in_word.u[0]));
        uy     = MW'($signed(in_word.u[1]));
        uz     = MW'($signed(in_word.u[2]));
        cos1   = in_word.flip ? -MW'(in_word.x) : MW'(in_word.x);
        sin1   = in_word.flip ? -MW'(in_word.y) : MW'(in_word.y);
        t1     = Q30_ONE - cos1;
        p_next[0] = mulq(ux, ux);
        p_next[1] = mulq(uy, uy);
        p_next[2] = mulq(uz, uz);
        p_next[3] = mulq(ux, uy);
        p_next[4] = mulq(ux, uz);
        p_next[5] = mulq(uy, uz);
        s_next[0] = mulq(ux, sin1);
        s_next[1] = mulq(uy, sin1);
        s_next[2] = mulq(uz, sin1);
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            q2_next[k] = mulq(p_reg[k], t_reg);
        end
    end

    always_comb begin
        e_next[0] = (MW+1)'(c2_reg)             + (MW+1)'($signed(q2_reg[0]));
        e_next[1] = (MW+1)'($signed(q2_reg[3])) - (MW+1)'($signed(s2_reg[2]));
        e_next[2] = (MW+1)'($signed(q2_reg[4])) + (MW+1)'($signed(s2_reg[1]));
        e_next[3] = (MW+1)'($signed(q2_reg[3])) + (MW+1)'($signed(s2_reg[2]));
        e_next[4] = (MW+1)'(c2_reg)             + (MW+1)'($signed(q2_reg[1]));
        e_next[5] = (MW+1)'($signed(q2_reg[5])) - (MW+1)'($signed(s2_reg[0]));
        e_next[6] = (MW+1)'($signed(q2_reg[4])) - (MW+1)'($signed(s2_reg[1]));
        e_next[7] = (MW+1)'($signed(q2_reg[5])) + (MW+1)'($signed(s2_reg[0]));
        e_next[8] = (MW+1)'(c2_reg)             + (MW+1)'($signed(q2_reg[2]));
        data_next = '0;
        for (int k = 0; k < N_ENTRIES; k++) begin
            if (zero2_reg) begin
                data_next[k*ENTRY_W +: ENTRY_W] = (k % 4 == 0) ? ONE_OUT : '0;
            end else begin
                data_next[k*ENTRY_W +: ENTRY_W] = to_out(e_next[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= in_valid;
            valid2_reg    <= valid_reg;
            out_valid_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= p_next;
            s_reg     <= s_next;
            c_reg     <= cos1;
            t_reg     <= t1;
            zero_reg  <= in_word.zero;
            q2_reg    <= q2_next;
            s2_reg    <= s_reg;
            c2_reg    <= c_reg;
            zero2_reg <= zero_reg;
            data_reg  <= data_next;
            user_reg  <= zero2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
